### rtl/omd_pkg.sv
// shared types and constants of the oversampled manchester decoder
`timescale 1ns / 1ps
package omd_pkg;

	localparam int SAMPLES        = 8;
	localparam int FIFO_DEPTH     = 4;
	localparam logic [2:0] PREAMBLE_RESET = 3'd4;
	localparam logic [1:0] RUN_MAX        = 2'd3;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// what one lane sees at its sample
	typedef struct packed {
		logic trans;
		logic is_long;
		logic overrun;
	} lane_flags_t;

	// level and run length handed into the first lane
	typedef struct packed {
		logic       level;
		logic [1:0] run;
	} seed_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] count;
		logic        last;
	} result_t;

	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t res0;
		result_t res1;
	} push_t;

endpackage

### rtl/omd_lane.sv
// one sample lane: transition detection and run length tracking
`timescale 1ns / 1ps
module omd_lane (
	input  logic                level,
	input  logic                prev_level,
	input  logic [1:0]          run_in,
	output omd_pkg::lane_flags_t flags,
	output logic [1:0]          run_out
);
	import omd_pkg::*;

	always_comb begin
		flags.trans   = level != prev_level;
		flags.is_long = run_in > 2'd1;
		flags.overrun = (level == prev_level) && (run_in == RUN_MAX);
		if (level != prev_level) begin
			run_out = 2'd0;
		end else if (run_in == RUN_MAX) begin
			run_out = RUN_MAX;
		end else begin
			run_out = run_in + 2'd1;
		end
	end

endmodule

### rtl/omd_merge.sv
// merging stage: walks the lane flags in order and keeps the decoder state
`timescale 1ns / 1ps
module omd_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic                                  start_req,
	input  omd_pkg::lane_flags_t [omd_pkg::SAMPLES-1:0] flags,
	input  logic [1:0]                            last_run,
	input  logic                                  last_level,
	output omd_pkg::seed_t                        seed,
	output omd_pkg::push_t                        push
);
	import omd_pkg::*;

	logic [2:0]  preamble_q;
	logic        prev_q;
	logic [1:0]  run_q;
	logic        pending_q;
	logic        cur_bit_q;
	logic [7:0]  partial_q;
	logic [2:0]  bitpos_q;
	logic [15:0] count_q;
	logic        finished_q;

	logic [2:0]  pl_n;
	logic        ps_n;
	logic        cb_n;
	logic [7:0]  pb_n;
	logic [2:0]  bp_n;
	logic [15:0] count_n;
	logic        stop_n;
	logic        got_byte;
	logic [7:0]  byte_val;
	logic        idle;

	always_comb begin
		seed.level = start_req ? 1'b0 : prev_q;
		seed.run   = start_req ? 2'd0 : run_q;
	end

	always_comb begin
		kind_t stop_kind;
		logic  emit;
		pl_n      = start_req ? PREAMBLE_RESET : preamble_q;
		ps_n      = start_req ? 1'b0 : pending_q;
		cb_n      = start_req ? 1'b1 : cur_bit_q;
		pb_n      = start_req ? 8'd0 : partial_q;
		bp_n      = start_req ? 3'd0 : bitpos_q;
		idle      = start_req ? 1'b0 : finished_q;
		stop_n    = 1'b0;
		stop_kind = KIND_END;
		got_byte  = 1'b0;
		byte_val  = 8'd0;
		for (int i = 0; i < SAMPLES; i++) begin
			emit = 1'b0;
			if (!stop_n) begin
				if (flags[i].trans) begin
					if (pl_n > 3'd2 && flags[i].is_long) begin
						pl_n = pl_n - 3'd1;
					end else if (pl_n <= 3'd2 && !flags[i].is_long && pl_n != 3'd0) begin
						pl_n = pl_n - 3'd1;
					end else if (pl_n == 3'd0) begin
						if (flags[i].is_long) begin
							if (ps_n) begin
								stop_n    = 1'b1;
								stop_kind = KIND_ERROR;
							end else begin
								cb_n = ~cb_n;
								emit = 1'b1;
							end
						end else if (ps_n) begin
							ps_n = 1'b0;
							emit = 1'b1;
						end else begin
							ps_n = 1'b1;
						end
					end
					if (emit) begin
						pb_n = pb_n | (8'(cb_n) << bp_n);
						bp_n = bp_n + 3'd1;
						if (bp_n == 3'd0) begin
							got_byte = 1'b1;
							byte_val = pb_n;
							pb_n     = 8'd0;
						end
					end
				end else if (flags[i].overrun) begin
					stop_n    = 1'b1;
					stop_kind = KIND_END;
				end
			end
		end
		count_n = (start_req ? 16'd0 : count_q) + 16'(got_byte);

		push.res0.kind  = got_byte ? KIND_DATA : stop_kind;
		push.res0.data  = got_byte ? byte_val : 8'd0;
		push.res0.count = count_n;
		push.res0.last  = !(got_byte && stop_n);
		push.res1.kind  = stop_kind;
		push.res1.data  = 8'd0;
		push.res1.count = count_n;
		push.res1.last  = 1'b1;
		push.push0      = accept && !idle && (got_byte || stop_n);
		push.push1      = accept && !idle && got_byte && stop_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PREAMBLE_RESET;
			prev_q     <= 1'b0;
			run_q      <= 2'd0;
			pending_q  <= 1'b0;
			cur_bit_q  <= 1'b1;
			partial_q  <= 8'd0;
			bitpos_q   <= 3'd0;
			count_q    <= 16'd0;
			finished_q <= 1'b1;
		end else if (accept && !idle) begin
			preamble_q <= pl_n;
			prev_q     <= last_level;
			run_q      <= last_run;
			pending_q  <= ps_n;
			cur_bit_q  <= cb_n;
			partial_q  <= pb_n;
			bitpos_q   <= bp_n;
			count_q    <= count_n;
			finished_q <= stop_n;
		end
	end

endmodule

### rtl/omd_out_fifo.sv
// result queue: takes up to two results a cycle, hands out one
`timescale 1ns / 1ps
module omd_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  omd_pkg::push_t   push,
	output logic             space_ok,
	output logic             out_valid,
	input  logic             out_ready,
	output omd_pkg::result_t out_res
);
	import omd_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	result_t       mem [FIFO_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          pop;
	logic [PW:0]   n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_res   = mem[rd_q];
	assign space_ok  = cnt_q <= (PW+1)'(FIFO_DEPTH - 2);
	assign n_push    = (PW+1)'(push.push0) + (PW+1)'(push.push1);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem[wr_q] <= push.res0;
		end
		if (push.push1) begin
			mem[wr_q + PW'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(n_push);
			rd_q  <= rd_q + PW'(pop);
			cnt_q <= cnt_q + n_push - (PW+1)'(pop);
		end
	end

endmodule

### rtl/oversampled_manchester_decoder.sv
// Results of an accepted word are registered in the result queue before they reach the master side.
// Throughput: one sample word per cycle while s_tready is high; the eight sample lanes and the merge
// resolve a word combinationally, and a word giving two results drains through a four-entry queue.
// s_tready drops only while the queue holds more than two results.
// Reset: arst_n clears the queue and puts the decoder idle until a word with start set.
`timescale 1ns / 1ps
module oversampled_manchester_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // sample_byte
	input  logic        s_tuser,   // start_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // data_byte [7:0], byte_count [23:8]
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast
);
	import omd_pkg::*;

	lane_flags_t [SAMPLES-1:0] flags;
	logic [1:0]  run_chain [SAMPLES+1];
	logic [SAMPLES:0] lvl_chain;
	seed_t       seed;
	push_t       push;
	result_t     out_res;
	logic        accept;

	assign accept       = s_tvalid && s_tready;
	assign run_chain[0] = seed.run;
	// level before the first sample sits above the word
	assign lvl_chain    = {seed.level, s_tdata};

	// lane i sees the i-th sample in time order, msb first
	for (genvar i = 0; i < SAMPLES; i++) begin : g_lane
		omd_lane u_lane (
			.level      (lvl_chain[SAMPLES-1-i]),
			.prev_level (lvl_chain[SAMPLES-i]),
			.run_in     (run_chain[i]),
			.flags      (flags[i]),
			.run_out    (run_chain[i+1])
		);
	end

	omd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.start_req  (s_tuser),
		.flags      (flags),
		.last_run   (run_chain[SAMPLES]),
		.last_level (s_tdata[0]),
		.seed       (seed),
		.push       (push)
	);

	omd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.count, out_res.data};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule
